/* hw/rtl/bap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_pkg: shared types and constants of the BLE AT response parser
// Command, result and capture codes, the descriptor word that the parser
// front end hands to the result back end, and the reply prefix table.
// ----------------------------------------------------------------------------
package bap_pkg;

   // Field limits of the captured replies
   localparam int ADDR_CHARS  = 12;
   localparam int NAME_CHARS  = 13;
   localparam int ID_END      = 6;
   localparam int MAX_RESULTS = 10;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Input command codes
   localparam logic [1:0] CMD_RX    = 2'd0;
   localparam logic [1:0] CMD_ISSUE = 2'd1;
   localparam logic [1:0] CMD_TX    = 2'd2;

   // Issued command kinds
   localparam logic [2:0] IK_NONE  = 3'd0;
   localparam logic [2:0] IK_AT    = 3'd1;
   localparam logic [2:0] IK_CHAR  = 3'd2;
   localparam logic [2:0] IK_NOTI  = 3'd3;
   localparam logic [2:0] IK_NOTP  = 3'd4;
   localparam logic [2:0] IK_NAME  = 3'd5;
   localparam logic [2:0] IK_UUID  = 3'd6;
   localparam logic [2:0] IK_START = 3'd7;

   // Result kinds
   localparam logic [2:0] RK_STATUS  = 3'd0;
   localparam logic [2:0] RK_DATA    = 3'd1;
   localparam logic [2:0] RK_CAPTURE = 3'd2;
   localparam logic [2:0] RK_GRANT   = 3'd3;
   localparam logic [2:0] RK_REFUSE  = 3'd4;

   // Capture targets
   localparam logic [1:0] TG_ADDR = 2'd0;
   localparam logic [1:0] TG_NAME = 2'd1;
   localparam logic [1:0] TG_CHAR = 2'd2;
   localparam logic [1:0] TG_SERV = 2'd3;

   // Refuse reasons
   localparam logic RR_WAITING  = 1'b0;
   localparam logic RR_NO_LINK  = 1'b1;

   // Reply branches, used to rebuild a failed prefix
   localparam logic [1:0] BR_LOST  = 2'd0;
   localparam logic [1:0] BR_CONN  = 2'd1;
   localparam logic [1:0] BR_START = 2'd2;
   localparam logic [1:0] BR_SET   = 2'd3;

   // Characters with a meaning of their own
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;

   typedef struct packed {
      logic link_up;
      logic started;
      logic awaiting;
      logic notify;
      logic notify_addr;
   } flags_type;

   // One entry per accepted input: a single result, or a replay burst
   typedef struct packed {
      logic       replay;
      logic [1:0] branch;
      logic [3:0] plen;
      logic [2:0] kind;
      logic [7:0] data;
      logic [1:0] target;
      logic [3:0] index;
      logic       reason;
      flags_type  flags;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Character at position pos of the prefix of a reply branch
   function automatic logic [7:0] prefix_char(input logic [1:0] branch,
                                              input logic [3:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (pos)
         4'd0: c = "O";
         4'd1: c = "K";
         4'd2: c = "+";
         4'd3: begin
            case (branch)
               BR_LOST: c = "L";
               BR_CONN: c = "C";
               default: c = "S";
            endcase
         end
         4'd4: begin
            case (branch)
               BR_LOST:  c = "O";
               BR_CONN:  c = "O";
               BR_START: c = "T";
               default:  c = "e";
            endcase
         end
         4'd5: begin
            case (branch)
               BR_LOST:  c = "S";
               BR_CONN:  c = "N";
               BR_START: c = "A";
               default:  c = "t";
            endcase
         end
         4'd6: begin
            case (branch)
               BR_LOST:  c = "T";
               BR_CONN:  c = "N";
               BR_START: c = "R";
               default:  c = "N";
            endcase
         end
         4'd7:    c = "a";
         4'd8:    c = "m";
         4'd9:    c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/ble_at_response_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_at_response_parser_unit: BLE module AT reply parser
// Classifies received bytes, issued-command notices and transmit requests,
// tracks the link flags and streams out one or more result words per input.
// ----------------------------------------------------------------------------
// Path: the first result word of an input reaches rsp through a queue entry,
//   then the output register, after the input word is accepted.
// Throughput: one input word per cycle while the descriptor queue has room;
//   the back end gives one result word per cycle while rsp is not stalled, and
//   an input causes 1 result, or up to 10 on a replay.
// Reset: synchronous, clears parser state, flags, queue and output valid bit;
//   no clearing pass, the unit accepts words the cycle after reset drops.
// ----------------------------------------------------------------------------
module ble_at_response_parser_unit
   import bap_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] byte_value, [10:8] issued_kind, rest zero
   input  logic [1:0]  req_tuser,  // [1:0] command
   // Result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] out_byte, [9:8] capture_target,
                                   // [13:10] capture_index, [14] link_up,
                                   // [15] module_started, [16] awaiting_reply,
                                   // [17] notify_on, [18] notify_addr_on,
                                   // [19] refuse_reason, rest zero
   output logic [2:0]  rsp_tuser,  // [2:0] result_kind
   output logic        rsp_tlast   // last result of this input
);

   qstat_type  qstat;
   logic       push;
   logic       pop;
   desc_type   push_data;
   desc_type   head;

   logic [7:0] out_byte;
   logic [1:0] capture_target;
   logic [3:0] capture_index;
   flags_type  flags;
   logic       refuse_reason;

   // Front end: parse and classify each accepted word, push one descriptor
   bap_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .command     (req_tuser),
      .byte_value  (req_tdata[7:0]),
      .issued_kind (req_tdata[10:8]),
      .qstat       (qstat),
      .push        (push),
      .push_data   (push_data)
   );

   // Queue: absorb replay bursts so the front end keeps taking words
   bap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // Back end: expand each descriptor into result words
   bap_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .result_kind    (rsp_tuser),
      .out_byte       (out_byte),
      .capture_target (capture_target),
      .capture_index  (capture_index),
      .last           (rsp_tlast),
      .flags          (flags),
      .refuse_reason  (refuse_reason)
   );

   // Pack the result fields, highest first
   assign rsp_tdata = {4'd0, refuse_reason, flags.notify_addr, flags.notify,
                       flags.awaiting, flags.started, flags.link_up,
                       capture_index, capture_target, out_byte};

endmodule

/* hw/rtl/bap_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_front: reply parser front end
// Accepts one word a cycle unless the queue is full, runs the reply recognizer
// and the link flags, and pushes one descriptor per word into the result queue.
// ----------------------------------------------------------------------------
module bap_front
   import bap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] command,
   input  logic [7:0] byte_value,
   input  logic [2:0] issued_kind,
   input  qstat_type  qstat,
   output logic       push,
   output desc_type   push_data
);

   typedef enum logic [27:0] {
      PS_IDLE = 28'b1 << 0,  PS_DATA = 28'b1 << 1,  PS_O    = 28'b1 << 2,
      PS_OK   = 28'b1 << 3,  PS_OKP  = 28'b1 << 4,  PS_L1   = 28'b1 << 5,
      PS_L2   = 28'b1 << 6,  PS_L3   = 28'b1 << 7,  PS_L4   = 28'b1 << 8,
      PS_L5   = 28'b1 << 9,  PS_C1   = 28'b1 << 10, PS_C2   = 28'b1 << 11,
      PS_C3   = 28'b1 << 12, PS_C4   = 28'b1 << 13, PS_C5   = 28'b1 << 14,
      PS_S    = 28'b1 << 15, PS_ST2  = 28'b1 << 16, PS_ST3  = 28'b1 << 17,
      PS_ST4  = 28'b1 << 18, PS_ST5  = 28'b1 << 19, PS_SE2  = 28'b1 << 20,
      PS_SET3 = 28'b1 << 21, PS_SET4 = 28'b1 << 22, PS_SN4  = 28'b1 << 23,
      PS_SN5  = 28'b1 << 24, PS_SN6  = 28'b1 << 25, PS_SN7  = 28'b1 << 26,
      PS_SN8  = 28'b1 << 27
   } pstate_type;

   localparam logic [7:0] ADDR_LIMIT = 8'(ADDR_CHARS);
   localparam logic [7:0] NAME_LIMIT = 8'(NAME_CHARS);
   localparam logic [7:0] ID_LIMIT   = 8'(ID_END);

   pstate_type state_ff, state_in;
   logic [7:0] count_ff, count_in;
   logic [2:0] issued_ff, issued_in;
   logic       wait_ff, wait_in;
   logic       conn_ff, conn_in;
   logic       start_ff, start_in;
   logic       noti_ff, noti_in;
   logic       notp_ff, notp_in;

   logic       eol;
   logic [7:0] count_m2;
   logic       fail;
   logic [1:0] fail_branch;
   logic [3:0] fail_len;
   logic       ev_replay;
   logic [2:0] ev_kind;
   logic [7:0] ev_data;
   logic [1:0] ev_target;
   logic [3:0] ev_index;
   logic       ev_reason;

   assign in_ready = !qstat.full;
   assign push     = in_valid && !qstat.full;
   assign eol      = (byte_value == CH_LF) || (byte_value == CH_CR);
   assign count_m2 = count_ff - 8'd2;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issued_in   = issued_ff;
      wait_in     = wait_ff;
      conn_in     = conn_ff;
      start_in    = start_ff;
      noti_in     = noti_ff;
      notp_in     = notp_ff;
      fail        = 1'b0;
      fail_branch = BR_LOST;
      fail_len    = 4'd0;
      ev_replay   = 1'b0;
      ev_kind     = RK_STATUS;
      ev_data     = 8'h00;
      ev_target   = TG_ADDR;
      ev_index    = 4'd0;
      ev_reason   = RR_WAITING;

      case (command)
         CMD_RX: begin
            case (state_ff)
               PS_IDLE: begin
                  if (byte_value == "O") begin
                     state_in = PS_O;
                  end else if (!eol) begin
                     state_in = PS_DATA;
                     ev_kind  = RK_DATA;
                     ev_data  = byte_value;
                  end
               end
               PS_DATA: begin
                  ev_kind = RK_DATA;
                  if (eol) begin
                     state_in = PS_IDLE;
                     wait_in  = 1'b0;
                     ev_data  = CH_LF;
                  end else begin
                     ev_data  = byte_value;
                  end
               end
               PS_L5: begin
                  if (eol) begin
                     state_in = PS_IDLE;
                     wait_in  = 1'b0;
                     conn_in  = 1'b0;
                  end
               end
               PS_C5: begin
                  if (eol) begin
                     state_in = PS_IDLE;
                     wait_in  = 1'b0;
                     conn_in  = 1'b1;
                     count_in = 8'd0;
                  end else begin
                     if (count_ff < ADDR_LIMIT) begin
                        ev_kind   = RK_CAPTURE;
                        ev_data   = byte_value;
                        ev_target = TG_ADDR;
                        ev_index  = count_ff[3:0];
                     end
                     if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
                  end
               end
               PS_ST5: begin
                  if (eol) begin
                     state_in = PS_IDLE;
                     wait_in  = 1'b0;
                     start_in = 1'b1;
                  end
               end
               PS_SET4: begin
                  if (eol) begin
                     state_in = PS_IDLE;
                     wait_in  = 1'b0;
                     count_in = 8'd0;
                  end else begin
                     case (issued_ff)
                        IK_CHAR, IK_UUID: begin
                           if (count_ff >= 8'd2 && count_ff < ID_LIMIT) begin
                              ev_kind   = RK_CAPTURE;
                              ev_data   = byte_value;
                              ev_target = (issued_ff == IK_CHAR) ? TG_CHAR : TG_SERV;
                              ev_index  = count_m2[3:0];
                           end
                        end
                        IK_NOTI: begin
                           if (byte_value == CH_ZERO)     noti_in = 1'b0;
                           else if (byte_value == CH_ONE) noti_in = 1'b1;
                        end
                        IK_NOTP: begin
                           if (byte_value == CH_ZERO)     notp_in = 1'b0;
                           else if (byte_value == CH_ONE) notp_in = 1'b1;
                        end
                        IK_NAME: begin
                           if (count_ff < NAME_LIMIT) begin
                              ev_kind   = RK_CAPTURE;
                              ev_data   = byte_value;
                              ev_target = TG_NAME;
                              ev_index  = count_ff[3:0];
                           end
                        end
                        default: ;
                     endcase
                     if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
                  end
               end
               PS_SN8: begin
                  if (eol) begin
                     state_in = PS_IDLE;
                     wait_in  = 1'b0;
                     count_in = 8'd0;
                  end else begin
                     if (count_ff < NAME_LIMIT) begin
                        ev_kind   = RK_CAPTURE;
                        ev_data   = byte_value;
                        ev_target = TG_NAME;
                        ev_index  = count_ff[3:0];
                     end
                     if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
                  end
               end
               // Prefix states: advance on the expected character, else fail
               PS_O: begin
                  if (byte_value == "K") state_in = PS_OK;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd1; end
               end
               PS_OK: begin
                  if (byte_value == "+") state_in = PS_OKP;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd2; end
               end
               PS_OKP: begin
                  if (byte_value == "L")      state_in = PS_L1;
                  else if (byte_value == "C") state_in = PS_C1;
                  else if (byte_value == "S") state_in = PS_S;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd3; end
               end
               PS_L1: begin
                  if (byte_value == "O") state_in = PS_L2;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd4; end
               end
               PS_L2: begin
                  if (byte_value == "S") state_in = PS_L3;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd5; end
               end
               PS_L3: begin
                  if (byte_value == "T") state_in = PS_L4;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd6; end
               end
               PS_L4: begin
                  if (byte_value == CH_COLON) state_in = PS_L5;
                  else begin fail = 1'b1; fail_branch = BR_LOST; fail_len = 4'd7; end
               end
               PS_C1: begin
                  if (byte_value == "O") state_in = PS_C2;
                  else begin fail = 1'b1; fail_branch = BR_CONN; fail_len = 4'd4; end
               end
               PS_C2: begin
                  if (byte_value == "N") state_in = PS_C3;
                  else begin fail = 1'b1; fail_branch = BR_CONN; fail_len = 4'd5; end
               end
               PS_C3: begin
                  if (byte_value == "N") state_in = PS_C4;
                  else begin fail = 1'b1; fail_branch = BR_CONN; fail_len = 4'd6; end
               end
               PS_C4: begin
                  if (byte_value == CH_COLON) state_in = PS_C5;
                  else begin fail = 1'b1; fail_branch = BR_CONN; fail_len = 4'd7; end
               end
               PS_S: begin
                  if (byte_value == "T")      state_in = PS_ST2;
                  else if (byte_value == "e") state_in = PS_SE2;
                  else begin fail = 1'b1; fail_branch = BR_START; fail_len = 4'd4; end
               end
               PS_ST2: begin
                  if (byte_value == "A") state_in = PS_ST3;
                  else begin fail = 1'b1; fail_branch = BR_START; fail_len = 4'd5; end
               end
               PS_ST3: begin
                  if (byte_value == "R") state_in = PS_ST4;
                  else begin fail = 1'b1; fail_branch = BR_START; fail_len = 4'd6; end
               end
               PS_ST4: begin
                  if (byte_value == "T") state_in = PS_ST5;
                  else begin fail = 1'b1; fail_branch = BR_START; fail_len = 4'd7; end
               end
               PS_SE2: begin
                  if (byte_value == "t") state_in = PS_SET3;
                  else begin fail = 1'b1; fail_branch = BR_SET; fail_len = 4'd5; end
               end
               PS_SET3: begin
                  if (byte_value == CH_COLON) state_in = PS_SET4;
                  else if (byte_value == "N") state_in = PS_SN4;
                  else begin fail = 1'b1; fail_branch = BR_SET; fail_len = 4'd6; end
               end
               PS_SN4: begin
                  if (byte_value == "a") state_in = PS_SN5;
                  else begin fail = 1'b1; fail_branch = BR_SET; fail_len = 4'd7; end
               end
               PS_SN5: begin
                  if (byte_value == "m") state_in = PS_SN6;
                  else begin fail = 1'b1; fail_branch = BR_SET; fail_len = 4'd8; end
               end
               PS_SN6: begin
                  if (byte_value == "e") state_in = PS_SN7;
                  else begin fail = 1'b1; fail_branch = BR_SET; fail_len = 4'd9; end
               end
               PS_SN7: begin
                  if (byte_value == CH_COLON) state_in = PS_SN8;
                  else begin fail = 1'b1; fail_branch = BR_SET; fail_len = 4'd10; end
               end
               default: begin
                  state_in = PS_IDLE;
                  wait_in  = 1'b0;
               end
            endcase

            // Failed prefix: a line end closes the line, anything else opens data
            if (fail) begin
               if (eol) begin
                  state_in = PS_IDLE;
                  wait_in  = 1'b0;
                  if (state_ff == PS_L4) begin
                     conn_in = 1'b0;
                  end else if (state_ff == PS_C4) begin
                     conn_in = 1'b1;
                  end else if (state_ff != PS_OK) begin
                     ev_replay = 1'b1;
                  end
               end else begin
                  state_in  = PS_DATA;
                  ev_replay = 1'b1;
               end
               if (ev_replay) begin
                  ev_kind = RK_DATA;
                  ev_data = byte_value;
               end
            end
         end
         CMD_ISSUE: begin
            if (issued_kind != IK_NONE) begin
               issued_in = issued_kind;
               wait_in   = 1'b1;
            end
         end
         CMD_TX: begin
            if (wait_ff) begin
               ev_kind   = RK_REFUSE;
               ev_reason = RR_WAITING;
            end else if (!conn_ff) begin
               ev_kind   = RK_REFUSE;
               ev_reason = RR_NO_LINK;
            end else begin
               ev_kind   = RK_GRANT;
               ev_data   = byte_value;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      push_data.replay            = ev_replay;
      push_data.branch            = fail_branch;
      push_data.plen              = fail_len;
      push_data.kind              = ev_kind;
      push_data.data              = ev_data;
      push_data.target            = ev_target;
      push_data.index             = ev_index;
      push_data.reason            = ev_reason;
      push_data.flags.link_up     = conn_in;
      push_data.flags.started     = start_in;
      push_data.flags.awaiting    = wait_in;
      push_data.flags.notify      = noti_in;
      push_data.flags.notify_addr = notp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= PS_IDLE;
         count_ff  <= 8'd0;
         issued_ff <= IK_NONE;
         wait_ff   <= 1'b0;
         conn_ff   <= 1'b0;
         start_ff  <= 1'b0;
         noti_ff   <= 1'b0;
         notp_ff   <= 1'b0;
      end else if (push) begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issued_ff <= issued_in;
         wait_ff   <= wait_in;
         conn_ff   <= conn_in;
         start_ff  <= start_in;
         noti_ff   <= noti_in;
         notp_ff   <= notp_in;
      end
   end

endmodule

/* hw/rtl/bap_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_queue: descriptor queue
// Short register FIFO between the parser front end and the result back end.
// ----------------------------------------------------------------------------
module bap_queue
   import bap_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_data,
   input  logic      pop,
   output desc_type  head,
   output qstat_type qstat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   desc_type      mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == FULL_CNT);
   assign head        = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("queue popped while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ff == rd_ff) |-> (qstat.empty || qstat.full))
      else $error("queue pointers meet with entries partly used");

endmodule

/* hw/rtl/bap_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_back: result back end
// Expands the queue head into result words, one per cycle unless rsp stalls,
// into the output register; a replay rebuilds the failed prefix from bap_pkg.
// ----------------------------------------------------------------------------
module bap_back
   import bap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   head,
   input  qstat_type  qstat,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [2:0] result_kind,
   output logic [7:0] out_byte,
   output logic [1:0] capture_target,
   output logic [3:0] capture_index,
   output logic       last,
   output flags_type  flags,
   output logic       refuse_reason
);

   localparam logic [3:0] LAST_CAP = 4'(MAX_RESULTS - 1);

   logic [3:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [2:0] kind_ff;
   logic [7:0] byte_ff;
   logic [1:0] target_ff;
   logic [3:0] index_ff;
   logic       last_ff;
   flags_type  flags_ff;
   logic       reason_ff;

   logic [3:0] last_pos;
   logic       word_last;
   logic       advance;
   logic [7:0] word_byte;

   assign last_pos  = head.replay ? ((head.plen > LAST_CAP) ? LAST_CAP : head.plen) : 4'd0;
   assign word_last = (pos_ff == last_pos);
   assign advance   = !qstat.empty && (!valid_ff || out_ready);
   assign pop       = advance && word_last;
   assign word_byte = (head.replay && pos_ff < head.plen) ?
                      prefix_char(head.branch, pos_ff) : head.data;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
         pos_in   = word_last ? 4'd0 : pos_ff + 4'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff   <= head.kind;
         byte_ff   <= word_byte;
         target_ff <= head.target;
         index_ff  <= head.index;
         last_ff   <= word_last;
         flags_ff  <= head.flags;
         reason_ff <= head.reason;
      end
   end

   assign out_valid      = valid_ff;
   assign result_kind    = kind_ff;
   assign out_byte       = byte_ff;
   assign capture_target = target_ff;
   assign capture_index  = index_ff;
   assign last           = last_ff;
   assign flags          = flags_ff;
   assign refuse_reason  = reason_ff;

   a_burst_holds_head: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 4'd0) |-> !qstat.empty)
      else $error("burst in progress without a queue head");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_CAP)
      else $error("burst position beyond the result limit");

   a_replay_is_data: assert property (@(posedge clock) disable iff (reset)
      advance && head.replay |=> result_kind == RK_DATA)
      else $error("replay word not marked as data");

endmodule

/* verif/ble_at_response_parser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_at_response_parser_unit_tb: self-checking bench for the AT reply parser
// Drives received bytes, issued-command notices and transmit requests into
// the parser, predicts result words with a behavioral parser of its own (typed
// table rows give the kind and byte) and checks each word on rsp against that
// prediction. A short directed table comes first, then randomized reply lines,
// broken replies, noise and transmit bursts, with random idling on both sides.
// ----------------------------------------------------------------------------
module ble_at_response_parser_unit_tb
   import bap_pkg::*;
();

   localparam int         CYCLE_LIMIT    = 200000;
   localparam int         RANDOM_WORDS   = 130;
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         SHOWN_ERRORS   = 10;
   // Command code outside the defined set; the parser must answer with status
   localparam logic [1:0] CMD_UNKNOWN    = 2'd3;

   // Parser position: one state per matched reply prefix, plus the field states
   typedef enum logic [4:0] {
      PS_IDLE, PS_TEXT, PS_O, PS_OK, PS_OKP,
      PS_L, PS_LO, PS_LOS, PS_LOST, PS_LOST_ADDR,
      PS_C, PS_CO, PS_CON, PS_CONN, PS_CONN_ADDR,
      PS_S, PS_ST, PS_STA, PS_STAR, PS_START,
      PS_SE, PS_SET, PS_SET_VAL,
      PS_SETN, PS_SETNA, PS_SETNAM, PS_SETNAME, PS_NAME_VAL
   } parse_state_type;

   // Shapes of well-formed reply lines used by the random part
   typedef enum int {
      RP_OK, RP_CONN, RP_LOST, RP_START, RP_SET, RP_SETNAME, RP_COUNT
   } reply_shape_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [1:0] target;
      logic [3:0] index;
      logic       last;
      logic       link_up;
      logic       started;
      logic       awaiting;
      logic       notify_on;
      logic       notify_addr_on;
      logic       reason;
   } reply_word_type;

   // One stimulus word; typed rows carry the single result they must cause
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] value;
      logic [2:0] kind;
      logic       typed;
      logic [2:0] want_kind;
      logic [7:0] want_value;
      logic       want_reason;
   } stim_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'd0;  // [7:0] byte_value, [10:8] issued_kind
   logic [1:0]  req_tuser  = 2'd0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] out_byte, [9:8] target, [13:10] index,
                                     // [18:14] flags, [19] refuse_reason
   logic [2:0]  rsp_tuser;           // [2:0] result_kind
   logic        rsp_tlast;

   // Predictor state
   parse_state_type rx_state = PS_IDLE;
   logic [7:0]      held_prefix[$];
   logic [7:0]      field_chars       = 8'd0;
   logic [2:0]      last_command_kind = IK_NONE;
   logic            link_up           = 1'b0;
   logic            started           = 1'b0;
   logic            awaiting          = 1'b0;
   logic            notify_on         = 1'b0;
   logic            notify_addr_on    = 1'b0;

   reply_word_type fresh_results[$];    // results of the word being predicted
   reply_word_type pending_replies[$];  // expected words not yet seen on rsp

   logic        calm      = 1'b0;    // no idling on either side while set
   logic        in_random = 1'b0;
   int unsigned cycle_count;
   int unsigned words_sent, directed_words, random_words;
   int unsigned results_checked, captures_seen, grants_seen, refusals_seen;
   int unsigned data_seen, mismatches;

   // Directed table: extremes, every command, and the special cases
   stim_row_type directed_rows [24] = '{
      // transmit straight after reset: no link yet
      '{CMD_TX,      8'hFF, IK_NONE,  1'b1, RK_REFUSE, 8'h00, RR_NO_LINK},
      // unknown command, and an issue notice of kind none: both ignored
      '{CMD_UNKNOWN, 8'hA5, IK_START, 1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_ISSUE,   8'h5A, IK_NONE,  1'b1, RK_STATUS, 8'h00, 1'b0},
      // line end while idle is dropped silently
      '{CMD_RX,      CH_LF, IK_UUID,  1'b1, RK_STATUS, 8'h00, 1'b0},
      // byte extremes open a data line, a line end closes it with a newline
      '{CMD_RX,      8'h00, IK_NONE,  1'b1, RK_DATA,   8'h00, 1'b0},
      '{CMD_RX,      8'hFF, IK_START, 1'b1, RK_DATA,   8'hFF, 1'b0},
      '{CMD_RX,      CH_CR, IK_NONE,  1'b1, RK_DATA,   CH_LF, 1'b0},
      // issue a command, then transmit while the reply is awaited
      '{CMD_ISSUE,   8'h00, IK_START, 1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_TX,      8'h5A, IK_AT,    1'b1, RK_REFUSE, 8'h00, RR_WAITING},
      // walk the longest prefix, then break it so the replay is cut at ten
      '{CMD_RX,      "O",   IK_NONE,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "K",   IK_CHAR,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "+",   IK_NONE,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "S",   IK_NOTI,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "e",   IK_NONE,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "t",   IK_NOTP,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "N",   IK_NONE,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "a",   IK_NAME,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "m",   IK_NONE,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "e",   IK_AT,    1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      "X",   IK_NONE,  1'b0, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      CH_LF, IK_NONE,  1'b1, RK_DATA,   CH_LF, 1'b0},
      // line end inside a failed prefix replays the prefix and the raw byte
      '{CMD_RX,      "O",   IK_UUID,  1'b1, RK_STATUS, 8'h00, 1'b0},
      '{CMD_RX,      CH_CR, IK_NONE,  1'b0, RK_STATUS, 8'h00, 1'b0},
      '{CMD_TX,      8'h00, IK_NONE,  1'b1, RK_REFUSE, 8'h00, RR_NO_LINK}
   };

   ble_at_response_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stall the result side at random, except through the calm stretch
   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Append one result; an input never causes more than MAX_RESULTS of them
   task automatic note_result(input logic [2:0] kind, input logic [7:0] value,
                              input logic [1:0] target, input logic [7:0] index,
                              input logic reason);
      reply_word_type r;
      if (fresh_results.size() < MAX_RESULTS) begin
         r        = '0;
         r.kind   = kind;
         r.value  = value;
         r.target = target;
         r.index  = index[3:0];
         r.reason = reason;
         fresh_results.push_back(r);
      end
   endtask

   task automatic count_char();
      if (field_chars != 8'd255) field_chars = field_chars + 8'd1;
   endtask

   task automatic go_idle();
      rx_state = PS_IDLE;
      awaiting = 1'b0;
      held_prefix.delete();
   endtask

   // Next prefix state on a matching byte, PS_IDLE when the byte breaks it
   function automatic parse_state_type match_next(parse_state_type st, logic [7:0] b);
      parse_state_type nxt;
      nxt = PS_IDLE;
      case (st)
         PS_O:       if (b == "K") nxt = PS_OK;
         PS_OK:      if (b == "+") nxt = PS_OKP;
         PS_OKP: begin
            if (b == "L") nxt = PS_L;
            else if (b == "C") nxt = PS_C;
            else if (b == "S") nxt = PS_S;
         end
         PS_L:       if (b == "O") nxt = PS_LO;
         PS_LO:      if (b == "S") nxt = PS_LOS;
         PS_LOS:     if (b == "T") nxt = PS_LOST;
         PS_LOST:    if (b == CH_COLON) nxt = PS_LOST_ADDR;
         PS_C:       if (b == "O") nxt = PS_CO;
         PS_CO:      if (b == "N") nxt = PS_CON;
         PS_CON:     if (b == "N") nxt = PS_CONN;
         PS_CONN:    if (b == CH_COLON) nxt = PS_CONN_ADDR;
         PS_S: begin
            if (b == "T") nxt = PS_ST;
            else if (b == "e") nxt = PS_SE;
         end
         PS_ST:      if (b == "A") nxt = PS_STA;
         PS_STA:     if (b == "R") nxt = PS_STAR;
         PS_STAR:    if (b == "T") nxt = PS_START;
         PS_SE:      if (b == "t") nxt = PS_SET;
         PS_SET: begin
            if (b == CH_COLON) nxt = PS_SET_VAL;
            else if (b == "N") nxt = PS_SETN;
         end
         PS_SETN:    if (b == "a") nxt = PS_SETNA;
         PS_SETNA:   if (b == "m") nxt = PS_SETNAM;
         PS_SETNAM:  if (b == "e") nxt = PS_SETNAME;
         PS_SETNAME: if (b == CH_COLON) nxt = PS_NAME_VAL;
         default:    nxt = PS_IDLE;
      endcase
      return nxt;
   endfunction

   // Replay the matched prefix and then the byte that broke it
   task automatic replay_prefix(input logic [7:0] b);
      foreach (held_prefix[i]) note_result(RK_DATA, held_prefix[i], 2'd0, 8'd0, 1'b0);
      note_result(RK_DATA, b, 2'd0, 8'd0, 1'b0);
      held_prefix.delete();
   endtask

   // One character of an OK+Set: value, interpreted by the last issued kind
   task automatic take_set_char(input logic [7:0] b);
      case (last_command_kind)
         IK_CHAR: begin
            if (field_chars >= 2 && field_chars < ID_END)
               note_result(RK_CAPTURE, b, TG_CHAR, field_chars - 8'd2, 1'b0);
         end
         IK_NOTI: begin
            if (b == CH_ZERO) notify_on = 1'b0;
            else if (b == CH_ONE) notify_on = 1'b1;
         end
         IK_NOTP: begin
            if (b == CH_ZERO) notify_addr_on = 1'b0;
            else if (b == CH_ONE) notify_addr_on = 1'b1;
         end
         IK_NAME: begin
            if (field_chars < NAME_CHARS)
               note_result(RK_CAPTURE, b, TG_NAME, field_chars, 1'b0);
         end
         IK_UUID: begin
            if (field_chars >= 2 && field_chars < ID_END)
               note_result(RK_CAPTURE, b, TG_SERV, field_chars - 8'd2, 1'b0);
         end
         default: ;
      endcase
      count_char();
   endtask

   task automatic take_rx_byte(input logic [7:0] b);
      logic            eol;
      parse_state_type nxt;
      parse_state_type was;
      eol = (b == CH_LF) || (b == CH_CR);
      case (rx_state)
         PS_IDLE: begin
            if (b == "O") begin
               rx_state = PS_O;
               held_prefix.push_back(b);
            end else if (!eol) begin
               rx_state = PS_TEXT;
               note_result(RK_DATA, b, 2'd0, 8'd0, 1'b0);
            end
         end
         PS_TEXT: begin
            if (eol) begin
               go_idle();
               note_result(RK_DATA, CH_LF, 2'd0, 8'd0, 1'b0);
            end else begin
               note_result(RK_DATA, b, 2'd0, 8'd0, 1'b0);
            end
         end
         // address after OK+LOST: consumed, never captured
         PS_LOST_ADDR: begin
            if (eol) begin
               go_idle();
               link_up = 1'b0;
            end
         end
         PS_CONN_ADDR: begin
            if (eol) begin
               go_idle();
               link_up     = 1'b1;
               field_chars = 8'd0;
            end else begin
               if (field_chars < ADDR_CHARS)
                  note_result(RK_CAPTURE, b, TG_ADDR, field_chars, 1'b0);
               count_char();
            end
         end
         PS_START: begin
            if (eol) begin
               go_idle();
               started = 1'b1;
            end
         end
         PS_SET_VAL: begin
            if (eol) begin
               go_idle();
               field_chars = 8'd0;
            end else begin
               take_set_char(b);
            end
         end
         PS_NAME_VAL: begin
            if (eol) begin
               go_idle();
               field_chars = 8'd0;
            end else begin
               if (field_chars < NAME_CHARS)
                  note_result(RK_CAPTURE, b, TG_NAME, field_chars, 1'b0);
               count_char();
            end
         end
         default: begin
            nxt = match_next(rx_state, b);
            was = rx_state;
            if (nxt != PS_IDLE) begin
               rx_state = nxt;
               held_prefix.push_back(b);
            end else if (eol) begin
               // bare OK, OK+LOST and OK+CONN close without replay
               if (was == PS_LOST) link_up = 1'b0;
               else if (was == PS_CONN) link_up = 1'b1;
               else if (was != PS_OK) replay_prefix(b);
               go_idle();
            end else begin
               replay_prefix(b);
               rx_state = PS_TEXT;
            end
         end
      endcase
   endtask

   task automatic predict_word(input logic [1:0] cmd, input logic [7:0] b,
                               input logic [2:0] kind);
      fresh_results.delete();
      case (cmd)
         CMD_RX: take_rx_byte(b);
         CMD_ISSUE: begin
            if (kind != IK_NONE) begin
               last_command_kind = kind;
               awaiting          = 1'b1;
            end
         end
         CMD_TX: begin
            if (awaiting) note_result(RK_REFUSE, 8'd0, 2'd0, 8'd0, RR_WAITING);
            else if (!link_up) note_result(RK_REFUSE, 8'd0, 2'd0, 8'd0, RR_NO_LINK);
            else note_result(RK_GRANT, b, 2'd0, 8'd0, 1'b0);
         end
         default: ;
      endcase
      if (fresh_results.size() == 0) note_result(RK_STATUS, 8'd0, 2'd0, 8'd0, 1'b0);
      // flags are the ones after the whole input, on every result word
      foreach (fresh_results[i]) begin
         fresh_results[i].last           = (i == fresh_results.size() - 1);
         fresh_results[i].link_up        = link_up;
         fresh_results[i].started        = started;
         fresh_results[i].awaiting       = awaiting;
         fresh_results[i].notify_on      = notify_on;
         fresh_results[i].notify_addr_on = notify_addr_on;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Present one word, hold it until accepted, then queue its results
   task automatic send_word(input stim_row_type row);
      reply_word_type want;
      while (!calm && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, row.kind, row.value};
      req_tuser  <= row.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(row.cmd, row.value, row.kind);
      if (row.typed) begin
         want        = fresh_results[fresh_results.size() - 1];
         want.kind   = row.want_kind;
         want.value  = row.want_value;
         want.target = 2'd0;
         want.index  = 4'd0;
         want.last   = 1'b1;
         want.reason = row.want_reason;
         pending_replies.push_back(want);
      end else begin
         foreach (fresh_results[i]) pending_replies.push_back(fresh_results[i]);
      end
      words_sent++;
      if (in_random && row.cmd != CMD_UNKNOWN &&
          !(row.cmd == CMD_ISSUE && row.kind == IK_NONE))
         random_words++;
   endtask

   task automatic send_plain(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [2:0] kind);
      send_word('{cmd, b, kind, 1'b0, 3'd0, 8'd0, 1'b0});
   endtask

   // Received byte; the kind bits are don't-care for the parser, so vary them
   task automatic send_rx(input logic [7:0] b);
      send_plain(CMD_RX, b, 3'($urandom_range(7)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_rx(s[i]);
   endtask

   function automatic string head_of(reply_shape_type shape);
      case (shape)
         RP_OK:      return "OK";
         RP_CONN:    return "OK+CONN:";
         RP_LOST:    return "OK+LOST:";
         RP_START:   return "OK+START";
         RP_SET:     return "OK+Set:";
         default:    return "OK+SetName:";
      endcase
   endfunction

   // Field character: mostly printable, sometimes any byte, flag digits on request
   function automatic logic [7:0] field_char(input logic flag_digits);
      if (flag_digits && $urandom_range(9) < 7) return $urandom_range(1) ? CH_ONE : CH_ZERO;
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(33, 126));
   endfunction

   function automatic logic [7:0] any_eol();
      return $urandom_range(1) ? CH_CR : CH_LF;
   endfunction

   // Well-formed reply line, optionally after an issue notice
   task automatic send_reply();
      reply_shape_type shape;
      string           head;
      int unsigned     n;
      if (rx_state != PS_IDLE) send_rx(CH_CR);
      if ($urandom_range(9) < 6)
         send_plain(CMD_ISSUE, 8'($urandom_range(255)), 3'($urandom_range(7)));
      shape = reply_shape_type'($urandom_range(RP_COUNT - 1));
      head  = head_of(shape);
      if ((shape == RP_CONN || shape == RP_LOST) && $urandom_range(1))
         head = head.substr(0, head.len() - 2);
      send_text(head);
      if (head[head.len() - 1] == CH_COLON) begin
         n = (shape == RP_SET) ? $urandom_range(7) : $urandom_range(15);
         repeat (n) send_rx(field_char(shape == RP_SET));
      end
      send_rx(any_eol());
      if ($urandom_range(9) < 3) send_rx(any_eol());
      if ($urandom_range(9) < 4)
         repeat ($urandom_range(1, 3))
            send_plain(CMD_TX, 8'($urandom_range(255)), 3'($urandom_range(7)));
   endtask

   // Reply cut short, then a byte that may or may not continue it
   task automatic send_broken();
      string       head;
      int unsigned cut;
      logic [7:0]  tail;
      if (rx_state != PS_IDLE) send_rx(CH_CR);
      head = head_of(reply_shape_type'($urandom_range(RP_COUNT - 1)));
      cut  = $urandom_range(1, head.len() - 1);
      send_text(head.substr(0, cut - 1));
      case ($urandom_range(3))
         0, 1:    tail = 8'($urandom_range(255));
         2:       tail = any_eol();
         default: tail = "X";
      endcase
      send_rx(tail);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i]);
      directed_words = words_sent;

      in_random = 1'b1;
      while (random_words < RANDOM_WORDS) begin
         calm = (random_words >= 60 && random_words < 100);
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: send_reply();
            12, 13, 14: send_broken();
            15, 16, 17:
               repeat ($urandom_range(1, 6))
                  send_plain(2'($urandom_range(3)), 8'($urandom_range(255)),
                             3'($urandom_range(7)));
            default:
               repeat ($urandom_range(1, 4))
                  send_plain(CMD_TX, 8'($urandom_range(255)), 3'($urandom_range(7)));
         endcase
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then watch a little longer for stray words
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input words (%0d from the table) and %0d result words",
               words_sent, directed_words, results_checked);
      $display("saw %0d data, %0d capture, %0d grant and %0d refusal words; %0d mismatches",
               data_seen, captures_seen, grants_seen, refusals_seen, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: ends a run that hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d result words still expected",
               cycle_count, pending_replies.size());
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   function automatic string describe(reply_word_type r);
      return $sformatf({"kind %0d byte %02h target %0d index %0d last %0b",
                        " flags %b%b%b%b%b reason %0b"},
                       r.kind, r.value, r.target, r.index, r.last, r.link_up, r.started,
                       r.awaiting, r.notify_on, r.notify_addr_on, r.reason);
   endfunction

   always @(posedge clock) begin
      reply_word_type got;
      reply_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind           = rsp_tuser;
         got.value          = rsp_tdata[7:0];
         got.target         = rsp_tdata[9:8];
         got.index          = rsp_tdata[13:10];
         got.last           = rsp_tlast;
         got.link_up        = rsp_tdata[14];
         got.started        = rsp_tdata[15];
         got.awaiting       = rsp_tdata[16];
         got.notify_on      = rsp_tdata[17];
         got.notify_addr_on = rsp_tdata[18];
         got.reason         = rsp_tdata[19];
         results_checked++;
         case (got.kind)
            RK_DATA:    data_seen++;
            RK_CAPTURE: captures_seen++;
            RK_GRANT:   grants_seen++;
            RK_REFUSE:  refusals_seen++;
            default: ;
         endcase
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("unexpected word at cycle %0d: %s", cycle_count, describe(got));
         end else begin
            want = pending_replies.pop_front();
            // compare every field, and keep the pad bits at zero
            if (got !== want || rsp_tdata[23:20] !== 4'd0) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("  expected %s", describe(want));
                  $display("  actual   %s pad %h", describe(got), rsp_tdata[23:20]);
               end
            end
         end
      end
   end

endmodule
